@@ hdl/gcd_pkg.sv @@
`default_nettype none
package gcd_pkg;

  localparam int CW = 34;
  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cs_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sq_t;

  // pi / 180e6 in Q62, rounded
  localparam logic [36:0] RAD_K =
    37'((64'h6487ED5110B4611A + 64'd45000000) / 64'd90000000);
  localparam cval_t GAIN = 34'sd652032874;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic signed [27:0] LAT_LIM = 28'sd90000000;
  localparam logic signed [28:0] LON_LIM = 29'sd180000000;
  localparam logic signed [29:0] TURN = 30'sd360000000;
  localparam logic [30:0] DIST_MAX = 31'h7FFFFFFF;
  localparam logic [29:0] R100_RST = 30'd637100000;

  function automatic cval_t atan_q30(input int unsigned i);
    cval_t r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: r = (i <= 30) ? cval_t'((64'd1 << (30 - i)) - 64'd1) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/gcd_if.sv @@
`default_nettype none
interface gcd_pts_if;
  logic valid;
  logic ready;
  logic signed [27:0] from_lat;
  logic signed [28:0] from_lon;
  logic signed [27:0] to_lat;
  logic signed [28:0] to_lon;
  modport source(output valid, from_lat, from_lon, to_lat, to_lon, input ready);
  modport sink(input valid, from_lat, from_lon, to_lat, to_lon, output ready);
endinterface

interface gcd_dist_if;
  logic valid;
  logic ready;
  logic [30:0] distance_cm;
  modport source(output valid, distance_cm, input ready);
  modport sink(input valid, distance_cm, output ready);
endinterface
`default_nettype wire

@@ hdl/gcd_cordic_cell.sv @@
`default_nettype none
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STEP = 0,
  parameter bit VEC = 1'b0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cs_t  d,
  output cs_t       q
);

  localparam cval_t ANG = atan_q30(STEP);

  cval_t dx;
  cval_t dy;
  logic  dir;
  cs_t   nxt;

  // rotation steers on z, vectoring drives y toward zero
  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    dir = VEC ? d.y[CW-1] : !d.z[CW-1];
    if (dir) begin
      nxt.x = d.x - dx;
      nxt.y = d.y + dy;
      nxt.z = d.z - ANG;
    end else begin
      nxt.x = d.x + dx;
      nxt.y = d.y - dy;
      nxt.z = d.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule
`default_nettype wire

@@ hdl/gcd_sqrt_cell.sv @@
`default_nettype none
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire sq_t  d,
  output sq_t       q
);

  localparam logic [63:0] BITV = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  sq_t         nxt;

  always_comb begin
    trial = d.res + BITV;
    if (d.v >= trial) begin
      nxt.v = d.v - trial;
      nxt.res = (d.res >> 1) + BITV;
    end else begin
      nxt.v = d.v;
      nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule
`default_nettype wire

@@ hdl/great_circle_distance_top.sv @@
// Path: input registers, radian conversion, rotation cells, product registers, square-root cells,
// vectoring cells, output registers. Throughput: one word per cycle unless the chain stalls; every stage is a register.
// The stages form a chain of cells. The chain stalls as a whole only while the output register holds a word not taken.
// Reset (rst, synchronous): clears all valid bits and loads earth radius 6371000 m.
`default_nettype none
module great_circle_distance_top import gcd_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gcd_pts_if.sink          pts,
  gcd_dist_if.source       result,
  input  wire logic        cfg_we,
  input  wire logic [22:0] cfg_wdata
);

  localparam int N = CORDIC_STEPS;
  localparam int LAT = 40 + 2 * N;

  function automatic logic [30:0] clamp_abs(input cval_t v);
    cval_t m;
    m = v[CW-1] ? -v : v;
    return (m > cval_t'({3'b0, Q30_ONE})) ? Q30_ONE : m[30:0];
  endfunction

  function automatic logic [30:0] clamp_pos(input cval_t v);
    logic [30:0] r;
    if (v[CW-1]) r = '0;
    else if (v > cval_t'({3'b0, Q30_ONE})) r = Q30_ONE;
    else r = v[30:0];
    return r;
  endfunction

  function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << 29);
    return p[60:30];
  endfunction

  logic [LAT-1:0] vld;
  logic           en;
  logic [29:0]    r100;

  assign en = !vld[LAT-1] || result.ready;
  assign pts.ready = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      r100 <= R100_RST;
    end else begin
      if (en) vld <= {vld[LAT-2:0], pts.valid};
      if (cfg_we) r100 <= 30'(cfg_wdata) * 30'd100;
    end
  end

  // front: saturate, differences, longitude wrap
  logic signed [27:0] lat1_s, lat2_s;
  logic signed [28:0] lon1_s, lon2_s;
  logic signed [29:0] dlon_raw;
  logic signed [28:0] dlat_c, dlon_c;
  logic signed [27:0] r0_lat1, r0_lat2;
  logic signed [28:0] r0_dlat, r0_dlon;

  always_comb begin
    lat1_s = (pts.from_lat > LAT_LIM) ? LAT_LIM :
             (pts.from_lat < -LAT_LIM) ? -LAT_LIM : pts.from_lat;
    lat2_s = (pts.to_lat > LAT_LIM) ? LAT_LIM :
             (pts.to_lat < -LAT_LIM) ? -LAT_LIM : pts.to_lat;
    lon1_s = (pts.from_lon > LON_LIM) ? LON_LIM :
             (pts.from_lon < -LON_LIM) ? -LON_LIM : pts.from_lon;
    lon2_s = (pts.to_lon > LON_LIM) ? LON_LIM :
             (pts.to_lon < -LON_LIM) ? -LON_LIM : pts.to_lon;
    dlat_c = {lat2_s[27], lat2_s} - {lat1_s[27], lat1_s};
    dlon_raw = {lon2_s[28], lon2_s} - {lon1_s[28], lon1_s};
    if (dlon_raw > 30'sd180000000) dlon_raw = dlon_raw - TURN;
    else if (dlon_raw < -30'sd180000000) dlon_raw = dlon_raw + TURN;
    dlon_c = dlon_raw[28:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_lat1 <= lat1_s;
      r0_lat2 <= lat2_s;
      r0_dlat <= dlat_c;
      r0_dlon <= dlon_c;
    end
  end

  // radian conversion: lanes 0,1 are half angles, 2,3 latitudes
  logic signed [28:0] ang [4];
  logic               r1_neg [4];
  logic [46:0]        r1_pl [4];
  logic [45:0]        r1_ph [4];
  cval_t              r2_z [4];
  cs_t                rot [4][N+1];

  assign ang[0] = r0_dlat;
  assign ang[1] = r0_dlon;
  assign ang[2] = {r0_lat1[27], r0_lat1};
  assign ang[3] = {r0_lat2[27], r0_lat2};

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam bit HALF = (l < 2);
    logic [28:0] mag;
    logic [65:0] full;
    logic [31:0] rmag;

    assign mag = ang[l][28] ? 29'(-ang[l]) : 29'(ang[l]);

    always_comb begin
      full = (66'(r1_ph[l]) << 19) + 66'(r1_pl[l]) +
             (HALF ? (66'd1 << 32) : (66'd1 << 31));
      rmag = HALF ? full[64:33] : full[63:32];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r1_neg[l] <= ang[l][28];
        r1_pl[l] <= 47'(mag[27:0]) * 47'(RAD_K[18:0]);
        r1_ph[l] <= 46'(mag[27:0]) * 46'(RAD_K[36:19]);
        r2_z[l] <= r1_neg[l] ? -cval_t'({2'b0, rmag}) : cval_t'({2'b0, rmag});
      end
    end

    assign rot[l][0] = '{x: GAIN, y: '0, z: r2_z[l]};

    for (genvar k = 0; k < N; k++) begin : g_rot
      gcd_cordic_cell #(.STEP(k), .VEC(1'b0)) u_cell (
        .clk(clk), .en(en), .d(rot[l][k]), .q(rot[l][k+1])
      );
    end
  end

  // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
  logic [30:0] g1_s1sq, g1_c12, g1_s2sq;
  logic [30:0] g2_s1sq, g2_t;
  logic [31:0] a_sum;
  logic [30:0] g3_a, g3_b;

  assign a_sum = 32'(g2_s1sq) + 32'(g2_t);

  always_ff @(posedge clk) begin
    if (en) begin
      g1_s1sq <= qmul(clamp_abs(rot[0][N].y), clamp_abs(rot[0][N].y));
      g1_s2sq <= qmul(clamp_abs(rot[1][N].y), clamp_abs(rot[1][N].y));
      g1_c12 <= qmul(clamp_pos(rot[2][N].x), clamp_pos(rot[3][N].x));
      g2_s1sq <= g1_s1sq;
      g2_t <= qmul(g1_c12, g1_s2sq);
      g3_a <= (a_sum > 32'(Q30_ONE)) ? Q30_ONE : a_sum[30:0];
      g3_b <= Q30_ONE - ((a_sum > 32'(Q30_ONE)) ? Q30_ONE : a_sum[30:0]);
    end
  end

  // sqrt(a) and sqrt(1-a), lane 0 and lane 1
  sq_t sq [2][33];

  assign sq[0][0] = '{v: {3'b0, g3_a, 30'b0}, res: '0};
  assign sq[1][0] = '{v: {3'b0, g3_b, 30'b0}, res: '0};

  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar k = 0; k < 32; k++) begin : g_step
      gcd_sqrt_cell #(.STEP(k)) u_cell (
        .clk(clk), .en(en), .d(sq[l][k]), .q(sq[l][k+1])
      );
    end
  end

  // central angle by vectoring
  cs_t at [N+1];

  assign at[0] = '{x: cval_t'({3'b0, sq[1][32].res[30:0]}),
                   y: cval_t'({3'b0, sq[0][32].res[30:0]}), z: '0};

  for (genvar k = 0; k < N; k++) begin : g_atan
    gcd_cordic_cell #(.STEP(k), .VEC(1'b1)) u_cell (
      .clk(clk), .en(en), .d(at[k]), .q(at[k+1])
    );
  end

  // distance = central * radius * 100, rounded, saturated
  logic [32:0] central;
  logic [46:0] h1_pl;
  logic [45:0] h1_ph;
  logic [63:0] dfull;
  logic [30:0] dq;

  assign central = at[N].z[CW-1] ? '0 : {at[N].z[31:0], 1'b0};
  assign dfull = (64'(h1_ph) << 17) + 64'(h1_pl) + (64'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      h1_pl <= 47'(central[16:0]) * 47'(r100);
      h1_ph <= 46'(central[32:17]) * 46'(r100);
      dq <= (dfull[63:30] > 34'(DIST_MAX)) ? DIST_MAX : dfull[60:30];
    end
  end

  assign result.distance_cm = dq;

  a_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !pts.ready)
    else $error("input taken while output word blocked");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    pts.valid && pts.ready |=> vld[0])
    else $error("accepted word not entered in chain");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    vld[5+N] |-> (32'(g3_a) + 32'(g3_b) == 32'(Q30_ONE)))
    else $error("a and 1-a do not sum to one");

  a_sqrt: assert property (@(posedge clk) disable iff (rst)
    vld[37+N] |-> (sq[0][32].res <= 64'(Q30_ONE) && sq[1][32].res <= 64'(Q30_ONE)))
    else $error("square root out of unit range");

endmodule
`default_nettype wire
